### hdl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants of the packet rule classifier
// Item and rule layouts, search result record, codes and the rule match check.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int RULE_COUNT_DEF  = 16;
  localparam int CLASS_COUNT_DEF = 16;

  // Item action codes
  localparam logic [1:0] ACT_PACKET   = 2'd0;
  localparam logic [1:0] ACT_RAW      = 2'd1;
  localparam logic [1:0] ACT_RULE_WR  = 2'd2;
  localparam logic [1:0] ACT_CLASS_WR = 2'd3;

  // Rule verdict codes (the two remaining codes mean no action)
  localparam logic [1:0] RV_DROP     = 2'd1;
  localparam logic [1:0] RV_CLASSIFY = 2'd2;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // Configuration register indexes
  localparam logic [2:0] CFG_MARKING_ON    = 3'd0;
  localparam logic [2:0] CFG_FILTERING_ON  = 3'd1;
  localparam logic [2:0] CFG_DSCP_ON       = 3'd2;
  localparam logic [2:0] CFG_DROP_DEFAULT  = 3'd3;
  localparam logic [2:0] CFG_MARK_MASK     = 3'd4;
  localparam logic [2:0] CFG_FALLBACK_MARK = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] mark_value;
    logic [5:0]  dscp_value;
    logic [1:0]  rule_verdict;
    logic [3:0]  class_no;
  } item_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  verdict;
    logic [3:0]  class_no;
  } rule_t;

  // Result of the search so far, handed along the chain with the item
  typedef struct packed {
    logic       found;
    logic [3:0] idx;
    logic [1:0] verdict;
    logic [3:0] cls;
  } hit_t;

  typedef struct packed {
    logic [31:0] mark;
    logic [5:0]  dscp;
  } class_entry_t;

  // Zero in a rule field means any. Ports only count for TCP and UDP; a rule
  // naming a port never matches another protocol.
  function automatic logic rule_match(rule_t r, item_t p);
    logic ok;
    logic l4;
    ok = (r.src_ip == 32'd0 || r.src_ip == p.src_ip) &&
         (r.dst_ip == 32'd0 || r.dst_ip == p.dst_ip) &&
         (r.protocol == 8'd0 || r.protocol == p.protocol);
    l4 = (p.protocol == PROTO_TCP) || (p.protocol == PROTO_UDP);
    if (l4) begin
      ok = ok && (r.sport == 16'd0 || r.sport == p.sport) &&
           (r.dport == 16'd0 || r.dport == p.dport);
    end else begin
      ok = ok && (r.sport == 16'd0) && (r.dport == 16'd0);
    end
    return ok;
  endfunction

endpackage

### hdl/prc_rule_cell.sv
// ----------------------------------------------------------------------------
// prc_rule_cell: one rule slot of the search chain
// Holds one rule, takes rule writes addressed to it and checks passing packets.
// ----------------------------------------------------------------------------
module prc_rule_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            filtering_on,
  input  logic            in_vld,
  input  prc_pkg::item_t  in_item,
  input  prc_pkg::hit_t   in_hit,
  output logic            out_vld,
  output prc_pkg::item_t  out_item,
  output prc_pkg::hit_t   out_hit
);

  logic           vld_r;
  prc_pkg::item_t item_r;
  prc_pkg::hit_t  hit_r;
  prc_pkg::hit_t  hit_nxt;
  logic           present_r;
  prc_pkg::rule_t rule_r;
  logic           wr_here;

  assign wr_here = in_vld && (in_item.action == prc_pkg::ACT_RULE_WR) &&
                   (32'(in_item.entry_index) == 32'(CELL_INDEX));

  // Only the first match counts, so an earlier hit passes through untouched.
  always_comb begin
    hit_nxt = in_hit;
    if ((in_item.action == prc_pkg::ACT_PACKET) && filtering_on && !in_hit.found &&
        present_r && prc_pkg::rule_match(rule_r, in_item)) begin
      hit_nxt.found   = 1'b1;
      hit_nxt.idx     = 4'(CELL_INDEX);
      hit_nxt.verdict = rule_r.verdict;
      hit_nxt.cls     = rule_r.class_no;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      present_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
      if (wr_here) begin
        present_r <= in_item.entry_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= in_item;
      hit_r  <= hit_nxt;
      if (wr_here) begin
        rule_r.src_ip   <= in_item.src_ip;
        rule_r.dst_ip   <= in_item.dst_ip;
        rule_r.protocol <= in_item.protocol;
        rule_r.sport    <= in_item.sport;
        rule_r.dport    <= in_item.dport;
        rule_r.verdict  <= in_item.rule_verdict;
        rule_r.class_no <= in_item.class_no;
      end
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;
  assign out_hit  = hit_r;

endmodule

### hdl/prc_class_stage.sv
// ----------------------------------------------------------------------------
// prc_class_stage: class table stage at the end of the rule chain
// Applies class writes and looks up the class of the matched rule.
// ----------------------------------------------------------------------------
module prc_class_stage #(
  parameter int CLASS_COUNT = prc_pkg::CLASS_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_vld,
  input  prc_pkg::item_t        in_item,
  input  prc_pkg::hit_t         in_hit,
  output logic                  out_vld,
  output prc_pkg::item_t        out_item,
  output prc_pkg::hit_t         out_hit,
  output prc_pkg::class_entry_t out_cls,
  output logic                  out_cls_ok
);

  localparam int CLS_AW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

  prc_pkg::class_entry_t cls_mem_r [CLASS_COUNT];
  logic [CLASS_COUNT-1:0] present_r;
  logic                  vld_r;
  prc_pkg::item_t        item_r;
  prc_pkg::hit_t         hit_r;
  prc_pkg::class_entry_t rd_r;
  logic                  cls_ok_r;
  logic [CLS_AW-1:0]     wr_addr;
  logic [CLS_AW-1:0]     rd_addr;
  logic                  wr_en;
  logic                  rd_in_range;
  prc_pkg::class_entry_t wr_data;

  assign wr_addr     = CLS_AW'(in_item.entry_index);
  assign rd_addr     = CLS_AW'(in_hit.cls);
  assign rd_in_range = 32'(in_hit.cls) < 32'(CLASS_COUNT);
  assign wr_en       = adv && in_vld && (in_item.action == prc_pkg::ACT_CLASS_WR) &&
                       (32'(in_item.entry_index) < 32'(CLASS_COUNT));
  assign wr_data.mark = in_item.mark_value;
  assign wr_data.dscp = in_item.dscp_value;

  // Class memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cls_mem_r[wr_addr] <= wr_data;
    end
    if (adv && rd_in_range) begin
      rd_r <= cls_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      vld_r     <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
      if (wr_en) begin
        present_r[wr_addr] <= in_item.entry_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r   <= in_item;
      hit_r    <= in_hit;
      cls_ok_r <= rd_in_range && present_r[rd_addr];
    end
  end

  assign out_vld    = vld_r;
  assign out_item   = item_r;
  assign out_hit    = hit_r;
  assign out_cls    = rd_r;
  assign out_cls_ok = cls_ok_r;

endmodule

### hdl/packet_rule_classifier.sv
// ----------------------------------------------------------------------------
// packet_rule_classifier: five-tuple first-match packet classifier
// A chain of rule cells searches the rules, a class stage looks up the class,
// and an output register holds the finished result.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Contents
//  in_*      input      in_valid / in_stall  packet header, rule or class write
//  out_*     output     out_valid / out_stall  verdict, mark, DSCP, hit slot
//  cfg_*     input      cfg_we               enables, mark mask, fallback mark
//
// An item passes through the RULE_COUNT rule cells and the class stage in
// that order and then waits in the output register, whose contents drive the
// output ports until the result is taken. The chain moves as one: a new item
// is accepted in every cycle in which the output register is empty or is
// being emptied, so the sustained rate is one item per cycle.
// Reset is synchronous and active low; it empties the chain and clears the
// rule and class present bits and the configuration registers.
// A stalled output freezes the whole chain and raises in_stall in the same
// cycle.
//
// Rule and class writes travel through the chain in order with the packets.
// A rule write is stored by the cell of its slot as it enters that cell, and
// a class write by the class stage, so every packet sees exactly the tables
// left by the items ahead of it. Rule contents are kept in the cells without
// reset; only the present bits decide whether a slot takes part.
module packet_rule_classifier #(
  parameter int RULE_COUNT  = prc_pkg::RULE_COUNT_DEF,
  parameter int CLASS_COUNT = prc_pkg::CLASS_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_entry_index,
  input  logic        in_entry_valid,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_sport,
  input  logic [15:0] in_dport,
  input  logic [31:0] in_mark_value,
  input  logic [5:0]  in_dscp_value,
  input  logic [1:0]  in_rule_verdict,
  input  logic [3:0]  in_class_no,
  // Result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_verdict,
  output logic [31:0] out_mark_out,
  output logic        out_dscp_rewrite,
  output logic [5:0]  out_dscp_out,
  output logic        out_rule_hit,
  output logic [3:0]  out_hit_index,
  // Configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // Configuration registers
  logic        marking_on_r;
  logic        filtering_on_r;
  logic        dscp_on_r;
  logic        drop_default_r;
  logic [31:0] mark_mask_r;
  logic [31:0] fallback_mark_r;

  // Whole chain moves when the output register can take a new result.
  logic adv;

  // Chain links: position 0 is the input port, position i+1 is cell i.
  logic           chain_vld  [RULE_COUNT+1];
  prc_pkg::item_t chain_item [RULE_COUNT+1];
  prc_pkg::hit_t  chain_hit  [RULE_COUNT+1];

  logic                  cs_vld;
  prc_pkg::item_t        cs_item;
  prc_pkg::hit_t         cs_hit;
  prc_pkg::class_entry_t cs_cls;
  logic                  cs_cls_ok;

  // Output register
  logic        out_valid_r;
  logic        verdict_r, verdict_nxt;
  logic [31:0] mark_r, mark_nxt;
  logic        rewrite_r, rewrite_nxt;
  logic [5:0]  dscp_r, dscp_nxt;
  logic        hit_r, hit_nxt;
  logic [3:0]  hit_idx_r, hit_idx_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marking_on_r    <= 1'b0;
      filtering_on_r  <= 1'b0;
      dscp_on_r       <= 1'b0;
      drop_default_r  <= 1'b0;
      mark_mask_r     <= 32'd0;
      fallback_mark_r <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prc_pkg::CFG_MARKING_ON:    marking_on_r    <= cfg_wdata[0];
        prc_pkg::CFG_FILTERING_ON:  filtering_on_r  <= cfg_wdata[0];
        prc_pkg::CFG_DSCP_ON:       dscp_on_r       <= cfg_wdata[0];
        prc_pkg::CFG_DROP_DEFAULT:  drop_default_r  <= cfg_wdata[0];
        prc_pkg::CFG_MARK_MASK:     mark_mask_r     <= cfg_wdata;
        prc_pkg::CFG_FALLBACK_MARK: fallback_mark_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input item enters the chain with an empty search result.
  assign chain_vld[0]              = in_valid;
  assign chain_item[0].action       = in_action;
  assign chain_item[0].entry_index  = in_entry_index;
  assign chain_item[0].entry_valid  = in_entry_valid;
  assign chain_item[0].src_ip       = in_src_ip;
  assign chain_item[0].dst_ip       = in_dst_ip;
  assign chain_item[0].protocol     = in_protocol;
  assign chain_item[0].sport        = in_sport;
  assign chain_item[0].dport        = in_dport;
  assign chain_item[0].mark_value   = in_mark_value;
  assign chain_item[0].dscp_value   = in_dscp_value;
  assign chain_item[0].rule_verdict = in_rule_verdict;
  assign chain_item[0].class_no     = in_class_no;
  assign chain_hit[0]               = '0;

  for (genvar g = 0; g < RULE_COUNT; g++) begin : g_cell
    prc_rule_cell #(
      .CELL_INDEX (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .adv          (adv),
      .filtering_on (filtering_on_r),
      .in_vld       (chain_vld[g]),
      .in_item      (chain_item[g]),
      .in_hit       (chain_hit[g]),
      .out_vld      (chain_vld[g+1]),
      .out_item     (chain_item[g+1]),
      .out_hit      (chain_hit[g+1])
    );
  end

  prc_class_stage #(
    .CLASS_COUNT (CLASS_COUNT)
  ) u_class (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (chain_vld[RULE_COUNT]),
    .in_item    (chain_item[RULE_COUNT]),
    .in_hit     (chain_hit[RULE_COUNT]),
    .out_vld    (cs_vld),
    .out_item   (cs_item),
    .out_hit    (cs_hit),
    .out_cls    (cs_cls),
    .out_cls_ok (cs_cls_ok)
  );

  // Final decision. Write items report all zeros; an unparsed packet keeps its
  // mark and passes. A matched rule never takes the fallback mark.
  always_comb begin
    verdict_nxt = 1'b0;
    mark_nxt    = 32'd0;
    rewrite_nxt = 1'b0;
    dscp_nxt    = 6'd0;
    hit_nxt     = 1'b0;
    hit_idx_nxt = 4'd0;
    unique case (cs_item.action)
      prc_pkg::ACT_PACKET: begin
        mark_nxt = cs_item.mark_value;
        if (cs_hit.found) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cs_hit.idx;
          if (cs_hit.verdict == prc_pkg::RV_DROP) begin
            verdict_nxt = 1'b1;
          end else begin
            if ((cs_hit.verdict == prc_pkg::RV_CLASSIFY) && cs_cls_ok) begin
              if (marking_on_r) begin
                mark_nxt = (cs_item.mark_value & ~mark_mask_r) |
                           (cs_cls.mark & mark_mask_r);
              end
              if (dscp_on_r) begin
                rewrite_nxt = 1'b1;
                dscp_nxt    = cs_cls.dscp;
              end
            end
            verdict_nxt = drop_default_r;
          end
        end else begin
          if (marking_on_r) begin
            mark_nxt = (cs_item.mark_value & ~mark_mask_r) |
                       (fallback_mark_r & mark_mask_r);
          end
          verdict_nxt = drop_default_r;
        end
      end
      prc_pkg::ACT_RAW: begin
        mark_nxt = cs_item.mark_value;
      end
      prc_pkg::ACT_RULE_WR,
      prc_pkg::ACT_CLASS_WR: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cs_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      verdict_r <= verdict_nxt;
      mark_r    <= mark_nxt;
      rewrite_r <= rewrite_nxt;
      dscp_r    <= dscp_nxt;
      hit_r     <= hit_nxt;
      hit_idx_r <= hit_idx_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = verdict_r;
  assign out_mark_out     = mark_r;
  assign out_dscp_rewrite = rewrite_r;
  assign out_dscp_out     = dscp_r;
  assign out_rule_hit     = hit_r;
  assign out_hit_index    = hit_idx_r;

  // An accepted item must be in the first cell in the next cycle.
  a_accept_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> chain_vld[0 + 1])
    else $error("accepted item did not enter the rule chain");

  // Without a hit the reported slot is zero.
  a_no_hit_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rule_hit |-> out_hit_index == 4'd0)
    else $error("hit index set without a rule hit");

  // A DSCP rewrite only comes from a matched classify rule.
  a_rewrite_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dscp_rewrite |-> out_rule_hit)
    else $error("DSCP rewrite without a rule hit");

  // The DSCP value is zero unless a rewrite is requested.
  a_dscp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dscp_rewrite |-> out_dscp_out == 6'd0)
    else $error("DSCP value without a rewrite request");

endmodule

### tb/packet_rule_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_rule_classifier_tb: self-checking testbench of the rule classifier
// A directed table followed by random phases under changing settings and
// handshake pressure; every result item is checked against its typed-in result or a local predictor.
// ----------------------------------------------------------------------------
module packet_rule_classifier_tb;

  localparam int NRULES      = prc_pkg::RULE_COUNT_DEF;
  localparam int NCLASSES    = prc_pkg::CLASS_COUNT_DEF;
  // Registers an accepted item passes: the rule cells, the class stage and the output register.
  localparam int LATENCY     = NRULES + 2;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 56;

  // The two rule verdict codes that carry no action.
  localparam logic [1:0] RV_NONE     = 2'd0;
  localparam logic [1:0] RV_NONE_ALT = 2'd3;

  // One result item as the block should report it.
  typedef struct packed {
    logic        verdict;
    logic [31:0] mark;
    logic        rewrite;
    logic [5:0]  dscp;
    logic        hit;
    logic [3:0]  slot;
  } outcome_t;

  // One full set of configuration registers.
  typedef struct packed {
    logic        marking;
    logic        filtering;
    logic        dscp;
    logic        drop_def;
    logic [31:0] mask;
    logic [31:0] fallback;
  } policy_t;

  // A row of the directed table: either a settings change or an item, the
  // latter with its result typed in where it is obvious.
  typedef struct packed {
    logic           reconfig;
    policy_t        pol;
    prc_pkg::item_t it;
    logic           typed;
    outcome_t       want;
  } row_t;

  localparam policy_t POL_MIXED = '{marking: 1'b1, filtering: 1'b1, dscp: 1'b1,
                                    drop_def: 1'b0, mask: 32'hFFFF_0000,
                                    fallback: 32'h1234_5678};
  localparam policy_t POL_STRICT = '{marking: 1'b1, filtering: 1'b1, dscp: 1'b1,
                                     drop_def: 1'b1, mask: 32'hFFFF_FFFF,
                                     fallback: 32'hFFFF_FFFF};
  localparam policy_t POL_NODSCP = '{marking: 1'b1, filtering: 1'b1, dscp: 1'b0,
                                     drop_def: 1'b0, mask: 32'h0000_0000,
                                     fallback: 32'hA5A5_A5A5};
  localparam policy_t POL_OFF = '{marking: 1'b0, filtering: 1'b0, dscp: 1'b0,
                                  drop_def: 1'b0, mask: 32'hFFFF_FFFF,
                                  fallback: 32'h0000_0000};

  // Clock, reset and every input of the block start at known values.
  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  prc_pkg::item_t drv_item  = '0;
  logic           out_stall = 1'b0;
  logic           cfg_we    = 1'b0;
  logic [2:0]     cfg_index = '0;
  logic [31:0]    cfg_wdata = '0;

  logic        in_stall;
  logic        out_valid;
  logic        out_verdict;
  logic [31:0] out_mark_out;
  logic        out_dscp_rewrite;
  logic [5:0]  out_dscp_out;
  logic        out_rule_hit;
  logic [3:0]  out_hit_index;

  // Predictor state: a private copy of both tables and of the registers.
  logic                  rule_on   [NRULES]   = '{default: 1'b0};
  prc_pkg::rule_t        rule_tab  [NRULES];
  logic                  class_on  [NCLASSES] = '{default: 1'b0};
  prc_pkg::class_entry_t class_tab [NCLASSES];
  policy_t               cur = '0;

  outcome_t pending [$];   // results owed by the block, oldest first
  row_t     directed [$];
  outcome_t head;
  int       mismatches     = 0;
  int       quiet          = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;

  packet_rule_classifier #(
    .RULE_COUNT (NRULES),
    .CLASS_COUNT(NCLASSES)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (drv_item.action),
    .in_entry_index  (drv_item.entry_index),
    .in_entry_valid  (drv_item.entry_valid),
    .in_src_ip       (drv_item.src_ip),
    .in_dst_ip       (drv_item.dst_ip),
    .in_protocol     (drv_item.protocol),
    .in_sport        (drv_item.sport),
    .in_dport        (drv_item.dport),
    .in_mark_value   (drv_item.mark_value),
    .in_dscp_value   (drv_item.dscp_value),
    .in_rule_verdict (drv_item.rule_verdict),
    .in_class_no     (drv_item.class_no),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_verdict     (out_verdict),
    .out_mark_out    (out_mark_out),
    .out_dscp_rewrite(out_dscp_rewrite),
    .out_dscp_out    (out_dscp_out),
    .out_rule_hit    (out_rule_hit),
    .out_hit_index   (out_hit_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial forever #1 clk = ~clk;

  // A rule field of zero is a wildcard. A rule that names a port can only
  // ever match TCP or UDP, because other protocols carry no ports.
  function automatic bit rule_accepts(prc_pkg::rule_t r, prc_pkg::item_t p);
    bit l4;
    l4 = (p.protocol == prc_pkg::PROTO_TCP) || (p.protocol == prc_pkg::PROTO_UDP);
    if (r.src_ip != '0 && r.src_ip != p.src_ip) return 1'b0;
    if (r.dst_ip != '0 && r.dst_ip != p.dst_ip) return 1'b0;
    if (r.protocol != '0 && r.protocol != p.protocol) return 1'b0;
    if (r.sport != '0 && (!l4 || r.sport != p.sport)) return 1'b0;
    if (r.dport != '0 && (!l4 || r.dport != p.dport)) return 1'b0;
    return 1'b1;
  endfunction

  // Works out the result of one accepted item and applies any table write
  // that it carries.
  function automatic outcome_t predict_outcome(prc_pkg::item_t it);
    outcome_t              o;
    prc_pkg::rule_t        r;
    prc_pkg::class_entry_t ce;
    bit                    found;
    logic [3:0]            at;
    o     = '0;
    r     = '0;
    ce    = '0;
    found = 1'b0;
    at    = '0;
    case (it.action)
      prc_pkg::ACT_RULE_WR: begin
        // A clearing write drops the present bit and blanks the slot.
        if (it.entry_valid) begin
          r.src_ip   = it.src_ip;
          r.dst_ip   = it.dst_ip;
          r.protocol = it.protocol;
          r.sport    = it.sport;
          r.dport    = it.dport;
          r.verdict  = it.rule_verdict;
          r.class_no = it.class_no;
        end
        rule_on[it.entry_index]  = it.entry_valid;
        rule_tab[it.entry_index] = r;
      end
      prc_pkg::ACT_CLASS_WR: begin
        if (it.entry_valid) begin
          ce.mark = it.mark_value;
          ce.dscp = it.dscp_value;
        end
        class_on[it.entry_index]  = it.entry_valid;
        class_tab[it.entry_index] = ce;
      end
      prc_pkg::ACT_RAW: o.mark = it.mark_value;
      default: begin
        o.mark = it.mark_value;
        if (cur.filtering) begin
          for (int s = 0; s < NRULES; s++) begin
            if (!found && rule_on[s] && rule_accepts(rule_tab[s], it)) begin
              found = 1'b1;
              at    = 4'(s);
            end
          end
        end
        if (!found) begin
          if (cur.marking) o.mark = (it.mark_value & ~cur.mask) | (cur.fallback & cur.mask);
          o.verdict = cur.drop_def;
        end else begin
          r      = rule_tab[at];
          o.hit  = 1'b1;
          o.slot = at;
          if (r.verdict == prc_pkg::RV_DROP) begin
            o.verdict = 1'b1;
          end else begin
            // A classify rule whose class is absent leaves mark and DSCP alone.
            if (r.verdict == prc_pkg::RV_CLASSIFY && class_on[r.class_no]) begin
              ce = class_tab[r.class_no];
              if (cur.marking) o.mark = (it.mark_value & ~cur.mask) | (ce.mark & cur.mask);
              if (cur.dscp) begin
                o.rewrite = 1'b1;
                o.dscp    = ce.dscp;
              end
            end
            o.verdict = cur.drop_def;
          end
        end
      end
    endcase
    return o;
  endfunction

  function automatic prc_pkg::item_t mk(logic [1:0] act, logic [3:0] idx, logic ev,
                               logic [31:0] sip, logic [31:0] dip, logic [7:0] proto,
                               logic [15:0] sp, logic [15:0] dp, logic [31:0] mark,
                               logic [5:0] dscp, logic [1:0] rv, logic [3:0] cls);
    prc_pkg::item_t it;
    it.action       = act;
    it.entry_index  = idx;
    it.entry_valid  = ev;
    it.src_ip       = sip;
    it.dst_ip       = dip;
    it.protocol     = proto;
    it.sport        = sp;
    it.dport        = dp;
    it.mark_value   = mark;
    it.dscp_value   = dscp;
    it.rule_verdict = rv;
    it.class_no     = cls;
    return it;
  endfunction

  task automatic add(prc_pkg::item_t it);
    directed.push_back('{reconfig: 1'b0, pol: '0, it: it, typed: 1'b0, want: '0});
  endtask

  task automatic add_known(prc_pkg::item_t it, outcome_t want);
    directed.push_back('{reconfig: 1'b0, pol: '0, it: it, typed: 1'b1, want: want});
  endtask

  task automatic add_policy(policy_t p);
    directed.push_back('{reconfig: 1'b1, pol: p, it: '0, typed: 1'b0, want: '0});
  endtask

  function automatic prc_pkg::item_t random_fields();
    prc_pkg::item_t it;
    it.action       = 2'($urandom_range(3));
    it.entry_index  = 4'($urandom_range(15));
    it.entry_valid  = 1'($urandom_range(1));
    it.src_ip       = $urandom;
    it.dst_ip       = $urandom;
    it.protocol     = 8'($urandom_range(255));
    it.sport        = 16'($urandom_range(65535));
    it.dport        = 16'($urandom_range(65535));
    it.mark_value   = $urandom;
    it.dscp_value   = 6'($urandom_range(63));
    it.rule_verdict = 2'($urandom_range(3));
    it.class_no     = 4'($urandom_range(15));
    return it;
  endfunction

  // Most packets copy a random slot's rule, if present, so that the search
  // really hits; some of those get one field spoilt, and the rest of the
  // traffic is table writes, unparsed packets and plain noise.
  function automatic prc_pkg::item_t draw_item();
    prc_pkg::item_t it;
    prc_pkg::rule_t r;
    int             pick;
    int             k;
    it   = random_fields();
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.action      = prc_pkg::ACT_RULE_WR;
      it.entry_valid = ($urandom_range(99) >= 15);
      if ($urandom_range(1) == 0) it.src_ip = '0;
      if ($urandom_range(1) == 0) it.dst_ip = '0;
      case ($urandom_range(5))
        0, 1: it.protocol = prc_pkg::PROTO_TCP;
        2, 3: it.protocol = prc_pkg::PROTO_UDP;
        4: it.protocol = '0;
        default: ;
      endcase
      if ($urandom_range(2) == 0) it.sport = '0;
      if ($urandom_range(2) == 0) it.dport = '0;
    end else if (pick < 18) begin
      it.action      = prc_pkg::ACT_CLASS_WR;
      it.entry_valid = ($urandom_range(99) >= 10);
    end else if (pick < 25) begin
      it.action = prc_pkg::ACT_RAW;
    end else if (pick < 35) begin
      it.action = prc_pkg::ACT_PACKET;
    end else begin
      it.action = prc_pkg::ACT_PACKET;
      k = $urandom_range(NRULES - 1);
      if (rule_on[k]) begin
        r = rule_tab[k];
        if (r.src_ip != '0) it.src_ip = r.src_ip;
        if (r.dst_ip != '0) it.dst_ip = r.dst_ip;
        if (r.protocol != '0) begin
          it.protocol = r.protocol;
        end else if ($urandom_range(2) != 0) begin
          it.protocol = ($urandom_range(1) == 0) ? prc_pkg::PROTO_TCP : prc_pkg::PROTO_UDP;
        end
        if (r.sport != '0) it.sport = r.sport;
        if (r.dport != '0) it.dport = r.dport;
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(4))
            0: it.src_ip ^= 32'd1 << $urandom_range(31);
            1: it.dst_ip ^= 32'd1 << $urandom_range(31);
            2: it.protocol ^= 8'd1 << $urandom_range(7);
            3: it.sport ^= 16'd1 << $urandom_range(15);
            default: it.dport ^= 16'd1 << $urandom_range(15);
          endcase
        end
      end
    end
    return it;
  endfunction

  // Offers one item, with random idle cycles in front of it, and holds it
  // until it is taken. The prediction is made at the edge of acceptance.
  task automatic send_item(prc_pkg::item_t it, logic typed, outcome_t want);
    outcome_t o;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    drv_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    o = predict_outcome(it);
    pending.push_back(typed ? want : o);
  endtask

  // Lets every result come out and the chain run empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_policy(policy_t p);
    cfg_write(prc_pkg::CFG_MARKING_ON, {31'd0, p.marking});
    cfg_write(prc_pkg::CFG_FILTERING_ON, {31'd0, p.filtering});
    cfg_write(prc_pkg::CFG_DSCP_ON, {31'd0, p.dscp});
    cfg_write(prc_pkg::CFG_DROP_DEFAULT, {31'd0, p.drop_def});
    cfg_write(prc_pkg::CFG_MARK_MASK, p.mask);
    cfg_write(prc_pkg::CFG_FALLBACK_MARK, p.fallback);
    cfg_we <= 1'b0;
    cur = p;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // The receiver stalls at the rate of the current phase.
  always @(posedge clk) out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);

  // Result checker: each result taken is held against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("result item arrived with nothing owed");
        mismatches++;
      end else begin
        head = pending.pop_front();
        check_field("verdict", 32'(head.verdict), 32'(out_verdict));
        check_field("mark_out", head.mark, out_mark_out);
        check_field("dscp_rewrite", 32'(head.rewrite), 32'(out_dscp_rewrite));
        check_field("dscp_out", 32'(head.dscp), 32'(out_dscp_out));
        check_field("rule_hit", 32'(head.hit), 32'(out_rule_hit));
        check_field("hit_index", 32'(head.slot), 32'(out_hit_index));
      end
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    policy_t pol;

    // Right after reset every register is zero: no search and no marking,
    // so packets come straight through.
    add_known(mk(prc_pkg::ACT_PACKET, '1, 1'b1, '1, '1, '1, '1, '1, '1, '1,
                 RV_NONE_ALT, '1),
              '{1'b0, 32'hFFFF_FFFF, 1'b0, 6'd0, 1'b0, 4'd0});
    add_known(mk(prc_pkg::ACT_PACKET, '0, 1'b0, '0, '0, '0, '0, '0, '0, '0, RV_NONE, '0),
              '0);
    add_known(mk(prc_pkg::ACT_RAW, '1, 1'b1, '1, '1, '1, '1, '1, 32'hDEAD_BEEF, '1,
                 RV_NONE_ALT, '1),
              '{1'b0, 32'hDEAD_BEEF, 1'b0, 6'd0, 1'b0, 4'd0});
    // Table writes give an all-zero result item.
    add_known(mk(prc_pkg::ACT_RULE_WR, 4'd0, 1'b1, 32'h0A00_0001, '0, prc_pkg::PROTO_TCP,
                 '0, 16'd80, '1, '1, prc_pkg::RV_DROP, '0), '0);
    add_known(mk(prc_pkg::ACT_RULE_WR, 4'd1, 1'b1, '0, 32'hC0A8_0001, '0, '0, '0,
                 32'h5555_AAAA, 6'd9, prc_pkg::RV_CLASSIFY, 4'd3), '0);
    add_known(mk(prc_pkg::ACT_RULE_WR, 4'd2, 1'b1, '0, '0, '0, '0, 16'd53, '0, '0,
                 prc_pkg::RV_CLASSIFY, 4'd5), '0);
    add_known(mk(prc_pkg::ACT_RULE_WR, 4'd15, 1'b1, '0, '0, '0, '0, '0, '0, '0,
                 RV_NONE_ALT, 4'd15), '0);
    add_known(mk(prc_pkg::ACT_RULE_WR, 4'd14, 1'b1, '0, '0, 8'd1, '0, '0, '0, '0,
                 RV_NONE, '0), '0);
    add_known(mk(prc_pkg::ACT_CLASS_WR, 4'd3, 1'b1, '0, '0, '0, '0, '0, 32'hCAFE_5A5A,
                 6'd46, RV_NONE, '0), '0);
    add_known(mk(prc_pkg::ACT_CLASS_WR, 4'd15, 1'b1, '0, '0, '0, '0, '0, '1, '1,
                 RV_NONE, '0), '0);
    add_policy(POL_MIXED);
    // A drop rule drops and keeps the mark.
    add_known(mk(prc_pkg::ACT_PACKET, '0, 1'b0, 32'h0A00_0001, 32'h0808_0808,
                 prc_pkg::PROTO_TCP, 16'd1234, 16'd80, 32'h1111_2222, '0, RV_NONE, '0),
              '{1'b1, 32'h1111_2222, 1'b0, 6'd0, 1'b1, 4'd0});
    // Wrong protocol for the drop rule: falls through to the catch-all rule.
    add(mk(prc_pkg::ACT_PACKET, '0, 1'b0, 32'h0A00_0001, 32'h0808_0808,
           prc_pkg::PROTO_UDP, 16'd1234, 16'd80, 32'h1111_2222, '0, RV_NONE, '0));
    // Classify rule with its class present: mark merged, DSCP rewritten.
    add(mk(prc_pkg::ACT_PACKET, '0, 1'b0, 32'h0A00_0002, 32'hC0A8_0001,
           prc_pkg::PROTO_TCP, 16'd5555, 16'd443, 32'h0000_00FF, '0, RV_NONE, '0));
    // A rule naming a port must not match a protocol without ports.
    add(mk(prc_pkg::ACT_PACKET, '0, 1'b0, 32'h0102_0304, 32'h0102_0304, 8'd1, 16'd53,
           16'd53, 32'h0F0F_0F0F, '0, RV_NONE, '0));
    // Classify rule whose class was never written.
    add(mk(prc_pkg::ACT_PACKET, '0, 1'b0, 32'h0102_0304, 32'h0102_0304,
           prc_pkg::PROTO_UDP, 16'd999, 16'd53, 32'h7777_0000, '0, RV_NONE, '0));
    add_known(mk(prc_pkg::ACT_RULE_WR, 4'd15, 1'b0, '1, '1, '1, '1, '1, '1, '1,
                 prc_pkg::RV_DROP, '1), '0);
    // Nothing matches now: the fallback mark is merged in.
    add(mk(prc_pkg::ACT_PACKET, '0, 1'b0, 32'h0102_0304, 32'h0506_0708, 8'd50, '0, '0,
           32'hAAAA_BBBB, '0, RV_NONE, '0));
    add_known(mk(prc_pkg::ACT_CLASS_WR, 4'd3, 1'b0, '1, '1, '1, '1, '1, '1, '1,
                 prc_pkg::RV_DROP, '1), '0);
    // Same classify rule after its class has been cleared.
    add(mk(prc_pkg::ACT_PACKET, '0, 1'b0, 32'h0A00_0009, 32'hC0A8_0001,
           prc_pkg::PROTO_TCP, 16'd7, 16'd443, 32'h1234_0000, '0, RV_NONE, '0));
    add_known(mk(prc_pkg::ACT_RAW, '0, 1'b0, 32'h0A00_0001, '0, prc_pkg::PROTO_TCP, '0,
                 16'd80, 32'h0BAD_F00D, '0, RV_NONE, '0),
              '{1'b0, 32'h0BAD_F00D, 1'b0, 6'd0, 1'b0, 4'd0});
    add_policy(POL_STRICT);
    add(mk(prc_pkg::ACT_PACKET, '0, 1'b0, 32'h0102_0304, 32'h0506_0708, 8'd50, '0, '0,
           32'h0000_0000, '0, RV_NONE, '0));
    add(mk(prc_pkg::ACT_PACKET, '0, 1'b0, 32'h0A00_0009, 32'hC0A8_0001,
           prc_pkg::PROTO_TCP, 16'd7, 16'd443, 32'h1234_0000, '0, RV_NONE, '0));
    add_known(mk(prc_pkg::ACT_RULE_WR, 4'd1, 1'b1, '0, 32'hC0A8_0001, prc_pkg::PROTO_UDP,
                 '0, '0, '0, '0, prc_pkg::RV_CLASSIFY, 4'd15), '0);
    add(mk(prc_pkg::ACT_PACKET, '0, 1'b0, 32'h0A00_0009, 32'hC0A8_0001,
           prc_pkg::PROTO_UDP, 16'hFFFF, 16'hFFFF, 32'h0000_0000, '0, RV_NONE, '0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].reconfig) begin
        drain();
        apply_policy(directed[i].pol);
      end else begin
        send_item(directed[i].it, directed[i].typed, directed[i].want);
      end
    end

    // Random phases: fixed extremes of the settings first, random ones after,
    // each under one of the four kinds of handshake pressure.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: pol = POL_STRICT;
        1: pol = POL_NODSCP;
        2: pol = POL_OFF;
        3: pol = POL_MIXED;
        default: begin
          pol.marking   = 1'($urandom_range(1));
          pol.filtering = ($urandom_range(3) != 0);
          pol.dscp      = 1'($urandom_range(1));
          pol.drop_def  = 1'($urandom_range(1));
          pol.mask      = $urandom;
          pol.fallback  = $urandom;
        end
      endcase
      drain();
      apply_policy(pol);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      repeat (PHASE_ITEMS) send_item(draw_item(), 1'b0, '0);
    end

    drain();
    if (mismatches == 0 && pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### packet_rule_classifier.f
hdl/prc_pkg.sv
hdl/prc_rule_cell.sv
hdl/prc_class_stage.sv
hdl/packet_rule_classifier.sv
tb/packet_rule_classifier_tb.sv
